FILE: sv/ilid_pkg.sv
// Shared definitions for the indexed list block: command and status codes
// and the control bundle broadcast to every list cell. No dependencies.
package ilid_pkg;

	localparam int CMD_W = 2;
	localparam int STATUS_W = 2;

	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_GET    = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// wr: place a value at the edit index and move later entries up.
	// del: drop the entry at the edit index and move later entries down.
	typedef struct packed {
		logic wr;
		logic del;
	} cell_ctrl_t;

endpackage

FILE: sv/indexed_list_insert_delete_top.sv
// Top level of the indexed list: a row of list cells, the count register and
// the result register. Depends on ilid_pkg and ilid_cell.
//
// Ordered list of up to DEPTH signed WIDTH-bit values. Each command transfer
// (append, insert at index, delete at index, get at index) yields exactly one
// result, offered from the next cycle and held until the sink takes it. The
// result carries read_value, the new length and a status (ok, full, index out
// of range). A failed command leaves the list untouched and returns
// read_value zero. Every cell moves its entry to a neighbor in parallel, so
// commands stream at one per cycle while the sink keeps stall low. A waiting
// result that the sink stalls holds off the next command. A command is taken
// while a waiting result is being transferred in the same cycle. No clearing
// pass after reset: only entries below the length are ever read.
module indexed_list_insert_delete_top
	import ilid_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic [CMD_W-1:0]              cmd,
	input  logic signed [WIDTH-1:0]       elem_value,
	input  logic [$clog2(DEPTH+1)-1:0]    position,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic signed [WIDTH-1:0]       read_value,
	output logic [$clog2(DEPTH+1)-1:0]    length,
	output logic [STATUS_W-1:0]           status
);

	localparam int LW = $clog2(DEPTH+1);
	localparam logic [LW-1:0] FULL_CNT = LW'(DEPTH);

	logic [LW-1:0]       count_q;
	logic                res_valid_q;
	logic [WIDTH-1:0]    read_value_q;
	logic [LW-1:0]       length_q;
	logic [STATUS_W-1:0] status_q;

	logic                take;
	cell_ctrl_t          ctrl;
	logic [LW-1:0]       edit_pos;
	logic [STATUS_W-1:0] st_next;
	logic [LW-1:0]       count_next;
	logic [WIDTH-1:0]    rd_next;
	logic [WIDTH-1:0]    cell_data [DEPTH];
	logic [WIDTH-1:0]    sel_data;

	// Hold the command while a result waits and the sink stalls.
	assign cmd_stall = res_valid_q & res_stall;
	assign take = cmd_valid & ~cmd_stall;

	// Pick the addressed entry: one-hot select, OR together.
	always_comb begin
		sel_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (position == LW'(i)) begin
				sel_data = sel_data | cell_data[i];
			end
		end
	end

	// Decode the command, check range and capacity, build the cell controls.
	always_comb begin
		ctrl = '0;
		edit_pos = position;
		st_next = ST_OK;
		count_next = count_q;
		rd_next = '0;
		unique case (cmd)
			CMD_APPEND: begin
				edit_pos = count_q;
				if (count_q >= FULL_CNT) begin
					st_next = ST_FULL;
				end else begin
					ctrl.wr = take;
					count_next = count_q + LW'(1);
				end
			end
			CMD_INSERT: begin
				if (position > count_q) begin
					st_next = ST_RANGE;
				end else if (count_q >= FULL_CNT) begin
					st_next = ST_FULL;
				end else begin
					ctrl.wr = take;
					count_next = count_q + LW'(1);
				end
			end
			CMD_DELETE: begin
				if (position >= count_q) begin
					st_next = ST_RANGE;
				end else begin
					ctrl.del = take;
					count_next = count_q - LW'(1);
				end
			end
			CMD_GET: begin
				if (position >= count_q) begin
					st_next = ST_RANGE;
				end else begin
					rd_next = sel_data;
				end
			end
			default: begin
				st_next = ST_RANGE;
			end
		endcase
	end

	// Row of cells; the ends take the new value and their own entry.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [WIDTH-1:0] lower;
		logic [WIDTH-1:0] upper;
		if (g == 0) begin : g_first
			assign lower = elem_value;
		end else begin : g_mid_lo
			assign lower = cell_data[g-1];
		end
		if (g == DEPTH-1) begin : g_last
			assign upper = cell_data[g];
		end else begin : g_mid_hi
			assign upper = cell_data[g+1];
		end
		ilid_cell #(
			.WIDTH(WIDTH),
			.LW(LW),
			.IDX(g)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.edit_pos(edit_pos),
			.new_value(elem_value),
			.lower_data(lower),
			.upper_data(upper),
			.data(cell_data[g])
		);
	end

	// Advance the count and the result flag on each transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q <= count_next;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: load on a command transfer, otherwise hold.
	always_ff @(posedge clk) begin
		if (take) begin
			read_value_q <= rd_next;
			length_q <= count_next;
			status_q <= st_next;
		end
	end

	assign res_valid = res_valid_q;
	assign read_value = read_value_q;
	assign length = length_q;
	assign status = status_q;

endmodule

FILE: sv/ilid_cell.sv
// One list slot: holds a single entry and takes its next value from the
// new item, its lower neighbor or its upper neighbor. Depends on ilid_pkg.
module ilid_cell
	import ilid_pkg::*;
#(
	parameter int WIDTH = 32,
	parameter int LW = 5,
	parameter int IDX = 0
) (
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [LW-1:0]    edit_pos,
	input  logic [WIDTH-1:0] new_value,
	input  logic [WIDTH-1:0] lower_data,
	input  logic [WIDTH-1:0] upper_data,
	output logic [WIDTH-1:0] data
);

	localparam logic [LW-1:0] MY_IDX = LW'(IDX);

	logic [WIDTH-1:0] data_q;

	// Entries hold payload only; no reset needed.
	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			if (MY_IDX == edit_pos) begin
				data_q <= new_value;
			end else if (MY_IDX > edit_pos) begin
				data_q <= lower_data;
			end
		end else if (ctrl.del) begin
			if (MY_IDX >= edit_pos) begin
				data_q <= upper_data;
			end
		end
	end

	assign data = data_q;

endmodule

FILE: sv/ilid_checker.sv
// Port-level checks for the indexed list top level, attached by bind.
// Depends on ilid_pkg and indexed_list_insert_delete_top.
module ilid_checker
	import ilid_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cmd_valid,
	input logic                       cmd_stall,
	input logic                       res_valid,
	input logic                       res_stall,
	input logic signed [WIDTH-1:0]    read_value,
	input logic [$clog2(DEPTH+1)-1:0] length,
	input logic [STATUS_W-1:0]        status
);

	localparam int LW = $clog2(DEPTH+1);

	// A stalled result stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	// Every command transfer yields a result in the next cycle.
	a_cmd_res: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> res_valid)
		else $error("command transfer without result");

	// Length never exceeds capacity.
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> length <= LW'(DEPTH))
		else $error("length above capacity");

	// A full status only comes with a full list and a zero read_value.
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_FULL |-> length == LW'(DEPTH) && read_value == '0)
		else $error("full status with list not full");

endmodule

bind indexed_list_insert_delete_top ilid_checker #(
	.DEPTH(DEPTH),
	.WIDTH(WIDTH)
) u_ilid_checker (.*);

FILE: test/ilid_list_sb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the indexed list testbench: a shadow copy of the list that
// predicts every reply, and the queue of replies still due. Depends on ilid_pkg.
package ilid_list_sb_pkg;
	import ilid_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int VAL_W = 32;
	localparam int POS_W = $clog2(LIST_DEPTH + 1);

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        len;
		logic [STATUS_W-1:0]     st;
	} list_reply_t;

	class list_scoreboard;
		logic signed [VAL_W-1:0] slots [LIST_DEPTH];
		int fill;
		list_reply_t replies_due [$];
		int errors;

		function new();
			fill = 0;
			errors = 0;
			foreach (slots[i]) slots[i] = '0;
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		function int pending();
			return replies_due.size();
		endfunction

		// Apply one accepted command to the shadow list and queue its reply.
		function void note_cmd(logic [CMD_W-1:0] op, logic signed [VAL_W-1:0] v,
				logic [POS_W-1:0] pos);
			list_reply_t r;
			int p;
			r.value = '0;
			r.st = ST_OK;
			p = int'(pos);
			case (op)
				CMD_APPEND: begin
					if (fill >= LIST_DEPTH) begin
						r.st = ST_FULL;
					end else begin
						slots[fill] = v;
						fill++;
					end
				end
				CMD_INSERT: begin
					// range is checked before fullness
					if (p > fill) begin
						r.st = ST_RANGE;
					end else if (fill >= LIST_DEPTH) begin
						r.st = ST_FULL;
					end else begin
						for (int i = fill; i > p; i--) slots[i] = slots[i-1];
						slots[p] = v;
						fill++;
					end
				end
				CMD_DELETE: begin
					if (p >= fill) begin
						r.st = ST_RANGE;
					end else begin
						for (int i = p; i + 1 < fill; i++) slots[i] = slots[i+1];
						fill--;
					end
				end
				CMD_GET: begin
					if (p >= fill) r.st = ST_RANGE;
					else r.value = slots[p];
				end
			endcase
			r.len = fill[POS_W-1:0];
			replies_due.push_back(r);
		endfunction

		task check_result(logic signed [VAL_W-1:0] rv, logic [POS_W-1:0] len,
				logic [STATUS_W-1:0] st);
			list_reply_t e;
			if (replies_due.size() == 0) begin
				report($sformatf("reply with none due: value %0d length %0d status %0d",
					rv, len, st));
				return;
			end
			e = replies_due.pop_front();
			if (rv !== e.value)
				report($sformatf("read_value %0d, want %0d", rv, e.value));
			if (len !== e.len)
				report($sformatf("length %0d, want %0d", len, e.len));
			if (st !== e.st)
				report($sformatf("status %0d, want %0d", st, e.st));
		endtask
	endclass

endpackage

FILE: test/tb_indexed_list_insert_delete_top.sv
`timescale 1ns / 1ps
// Top level of the indexed list testbench: clock, reset, command driver and
// reply checker. Depends on ilid_pkg, ilid_list_sb_pkg and the block's top.
module tb_indexed_list_insert_delete_top;
	import ilid_pkg::*;
	import ilid_list_sb_pkg::*;

	localparam int RANDOM_CMDS = 950;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_MAX = ~VAL_MIN;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	logic [CMD_W-1:0] cmd = CMD_GET;
	logic signed [VAL_W-1:0] elem_value = '0;
	logic [POS_W-1:0] position = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic signed [VAL_W-1:0] read_value;
	logic [POS_W-1:0] length;
	logic [STATUS_W-1:0] status;

	list_scoreboard board;
	int cycle_count = 0;
	bit tx_calm = 1'b0;	// sender runs back to back while set
	bit rx_calm = 1'b0;	// receiver never stalls while set
	int drain_wait = 0;

	indexed_list_insert_delete_top #(
		.DEPTH(LIST_DEPTH),
		.WIDTH(VAL_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.elem_value(elem_value),
		.position(position),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.read_value(read_value),
		.length(length),
		.status(status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop: far beyond the slowest legal run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Reply side: check every transfer, then draw how long to hold stall
	// before taking the next one. Calm stretches keep stall low throughout.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				board.check_result(read_value, length, status);
				if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
				drain_wait = rx_calm ? 0 : $urandom_range(0, 5);
			end else if (drain_wait > 0) begin
				drain_wait--;
			end
			res_stall <= (drain_wait != 0);
		end
	end

	// Drive one command: idle for a drawn gap, present the command and hold
	// it until the transfer. Call only right after a rising edge.
	task send_cmd(logic [CMD_W-1:0] op, logic signed [VAL_W-1:0] v, int pos);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= op;
		elem_value <= v;
		position <= pos[POS_W-1:0];
		do @(posedge clk); while (cmd_stall);
		board.note_cmd(op, v, pos[POS_W-1:0]);
	endtask

	// Hold off the sender until every reply due has come back.
	task drain_replies();
		cmd_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	function logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 19))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return '0;
			3: return -1;
			default: return $urandom;
		endcase
	endfunction

	// Mostly legal indexes for the current length; now and then any index from zero
	// up to the list depth, so range errors keep showing up.
	function int pick_position(logic [CMD_W-1:0] op, int fill);
		if ($urandom_range(0, 99) < 15) return $urandom_range(0, LIST_DEPTH);
		if (op == CMD_INSERT) return $urandom_range(0, fill);
		if (fill == 0) return 0;
		return $urandom_range(0, fill - 1);
	endfunction

	initial begin
		bit growing;
		int roll;
		logic [CMD_W-1:0] op;
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list errors, inserts at front, middle and end,
		// reads of every slot, range edges, then fill up and hit the full cases.
		send_cmd(CMD_GET, 0, 0);
		send_cmd(CMD_DELETE, 0, 0);
		send_cmd(CMD_INSERT, 5, 1);
		send_cmd(CMD_INSERT, VAL_MIN, 0);
		send_cmd(CMD_APPEND, VAL_MAX, 0);
		send_cmd(CMD_INSERT, -1, 1);
		send_cmd(CMD_INSERT, 32'sh5a5a_a5a5, 3);
		for (int i = 0; i < 4; i++) send_cmd(CMD_GET, 0, i);
		send_cmd(CMD_GET, 0, 4);
		send_cmd(CMD_DELETE, 0, 3);
		send_cmd(CMD_DELETE, 0, 0);
		while (board.fill < LIST_DEPTH)
			send_cmd(board.fill[0] ? CMD_APPEND : CMD_INSERT, pick_value(), 0);
		send_cmd(CMD_APPEND, 1, 0);
		send_cmd(CMD_INSERT, 2, LIST_DEPTH);
		send_cmd(CMD_INSERT, 3, 7);
		send_cmd(CMD_GET, 0, LIST_DEPTH - 1);
		send_cmd(CMD_GET, 0, LIST_DEPTH);
		send_cmd(CMD_DELETE, 0, LIST_DEPTH - 1);
		drain_replies();
		@(posedge clk);

		// Random: let the length wander between empty and full by biasing
		// toward growth or shrinkage, flipping the trend at the ends.
		growing = 1'b0;
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (board.fill == 0) growing = 1'b1;
			else if (board.fill == LIST_DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
			if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
			roll = $urandom_range(0, 99);
			if (growing)
				op = roll < 30 ? CMD_APPEND : roll < 60 ? CMD_INSERT :
					roll < 70 ? CMD_DELETE : CMD_GET;
			else
				op = roll < 10 ? CMD_APPEND : roll < 20 ? CMD_INSERT :
					roll < 65 ? CMD_DELETE : CMD_GET;
			send_cmd(op, pick_value(), pick_position(op, board.fill));
			if (n % 250 == 249) begin
				drain_replies();
				@(posedge clk);
			end
		end

		// Wind down: drop valid, wait out the replies, then a few spare cycles
		// to catch anything unexpected.
		drain_replies();
		repeat (8) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: indexed_list_insert_delete_top.f
sv/ilid_pkg.sv
sv/ilid_cell.sv
sv/indexed_list_insert_delete_top.sv
sv/ilid_checker.sv
test/ilid_list_sb_pkg.sv
test/tb_indexed_list_insert_delete_top.sv
